### src/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### src/ppse_pkg.sv
package ppse_pkg;
    localparam int DW = 32;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    localparam logic REG_SEGMENTS     = 1'b0;
    localparam logic REG_COEFFICIENTS = 1'b1;

    localparam logic [1:0] ORDER_VALUE    = 2'd0;
    localparam logic [1:0] ORDER_VELOCITY = 2'd1;
    localparam logic [1:0] ORDER_ACCEL    = 2'd2;
    localparam logic [1:0] ORDER_NONE     = 2'd3;

    typedef enum logic [1:0] {
        KIND_BOUNDS = 2'd0,
        KIND_COEF   = 2'd1,
        KIND_EVAL   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic op_start;
        logic srch_init;
        logic srch_step;
        logic coef_load;
        logic horner_init;
        logic horner_step;
        logic result_zero;
        logic result_take;
    } cmd_t;

    typedef struct packed {
        logic srch_done;
        logic order_bad;
        logic horner_last;
    } status_t;
endpackage

### src/ppse_if.sv
interface ppse_in_if;
    import ppse_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [3:0]        segment_index;
    logic [2:0]        coefficient_index;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic signed [31:0] coefficient_value;
    logic signed [31:0] sample_point;
    logic [1:0]        derivative_order;
    logic              wrap_unit;
    modport source (output valid, kind, segment_index, coefficient_index, lower_bound,
                    upper_bound, coefficient_value, sample_point, derivative_order,
                    wrap_unit, input ready);
    modport sink (input valid, kind, segment_index, coefficient_index, lower_bound,
                  upper_bound, coefficient_value, sample_point, derivative_order,
                  wrap_unit, output ready);
endinterface

interface ppse_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               saturated;
    modport source (output valid, value, saturated, input ready);
    modport sink (input valid, value, saturated, output ready);
endinterface

### src/ppse_ram.sv
module ppse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
endmodule

### src/ppse_ctrl.sv
module ppse_ctrl
    import ppse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_fire,
    input  logic    is_eval,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd,
    output logic    in_ready,
    output logic    out_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLAMP0, S_CLAMP1, S_SRCH0, S_SRCH1, S_COEF0, S_COEF1,
        S_HINIT, S_HMUL, S_HADD, S_OUT
    } state_t;
    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.op_start = 1'b1;
                    if (is_eval)
                    begin
                        state_next = S_CLAMP0;
                    end
                    else
                    begin
                        cmd.result_zero = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_CLAMP0: state_next = S_CLAMP1;
            S_CLAMP1:
            begin
                cmd.srch_init = 1'b1;
                state_next = S_SRCH0;
            end
            S_SRCH0:
            begin
                if (status.srch_done)
                begin
                    state_next = S_COEF0;
                end
                else
                begin
                    state_next = S_SRCH1;
                end
            end
            S_SRCH1:
            begin
                cmd.srch_step = 1'b1;
                state_next = S_SRCH0;
            end
            S_COEF0:
            begin
                if (status.order_bad)
                begin
                    cmd.result_zero = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.coef_load = 1'b1;
                    state_next = S_COEF1;
                end
            end
            S_COEF1:
            begin
                state_next = S_HINIT;
            end
            S_HINIT:
            begin
                cmd.horner_init = 1'b1;
                state_next = S_HMUL;
            end
            S_HMUL:
            begin
                if (status.horner_last)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_HADD;
                end
            end
            S_HADD:
            begin
                cmd.horner_step = 1'b1;
                state_next = S_HMUL;
            end
            S_OUT:
            begin
                cmd.result_take = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

### src/ppse_dp.sv
module ppse_dp
    import ppse_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int MAX_COEFFICIENTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               in_fire,
    input  logic [1:0]         kind,
    input  logic [3:0]         segment_index,
    input  logic [2:0]         coefficient_index,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    input  logic signed [31:0] coefficient_value,
    input  logic signed [31:0] sample_point,
    input  logic [1:0]         derivative_order,
    input  logic               wrap_unit,
    input  cmd_t               cmd,
    output status_t            status,
    output logic signed [31:0] value,
    output logic               saturated
);
    localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = (MAX_COEFFICIENTS > 1) ? $clog2(MAX_COEFFICIENTS) : 1;
    localparam int AW = $clog2(MAX_SEGMENTS * MAX_COEFFICIENTS) > 0 ?
                        $clog2(MAX_SEGMENTS * MAX_COEFFICIENTS) : 1;
    localparam int TW = AW > 0 ? AW : 1;
    localparam logic signed [63:0] QMAX = 64'sd2147483647;
    localparam logic signed [63:0] QMIN = -64'sd2147483648;

    logic [4:0] nseg_raw_reg;
    logic [3:0] ncoef_raw_reg;
    logic [SW:0] nseg;
    logic [4:0]  ncoef;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nseg_raw_reg <= 5'd1;
            ncoef_raw_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SEGMENTS)
            begin
                nseg_raw_reg <= cfg_data;
            end
            else
            begin
                ncoef_raw_reg <= cfg_data[3:0];
            end
        end
    end

    always_comb
    begin
        if (nseg_raw_reg == 5'd0)
        begin
            nseg = (SW+1)'(1);
        end
        else if (32'(nseg_raw_reg) > MAX_SEGMENTS)
        begin
            nseg = (SW+1)'(MAX_SEGMENTS);
        end
        else
        begin
            nseg = (SW+1)'(nseg_raw_reg);
        end
        if (ncoef_raw_reg == 4'd0)
        begin
            ncoef = 5'd1;
        end
        else if (32'(ncoef_raw_reg) > MAX_COEFFICIENTS)
        begin
            ncoef = 5'(MAX_COEFFICIENTS);
        end
        else
        begin
            ncoef = {1'b0, ncoef_raw_reg};
        end
    end

    // operation registers
    logic signed [31:0] x_reg;
    logic [1:0]         order_reg;
    logic [SW-1:0]      lo_reg, hi_reg;
    logic               sat_reg;
    logic signed [31:0] result_reg;
    logic               sat_out_reg;
    logic [4:0]         j_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] d_reg;
    logic signed [63:0] prod_reg;
    logic [1:0]         clamp_ph_reg;

    // bounds memories: port A for search/clamp
    logic [SW-1:0] b_raddr;
    logic [31:0]   st_rdata, en_rdata, st0_rdata;
    logic          wr_bounds, wr_coef;
    logic          seg_ok, ci_ok;
    assign seg_ok = 32'(segment_index) < MAX_SEGMENTS;
    assign ci_ok  = 32'(coefficient_index) < MAX_COEFFICIENTS;
    assign wr_bounds = in_fire && kind == KIND_BOUNDS && seg_ok;
    assign wr_coef   = in_fire && kind == KIND_COEF && seg_ok && ci_ok;

    logic [SW-1:0] mid;
    logic [SW:0]   midsum;
    assign midsum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid = midsum[SW:1];

    always_comb
    begin
        if (cmd.op_start)
        begin
            b_raddr = '0;
        end
        else if (clamp_ph_reg == 2'd1)
        begin
            b_raddr = SW'(nseg - 1'b1);
        end
        else
        begin
            b_raddr = mid;
        end
    end

    ppse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_starts (
        .clk(clk), .we(wr_bounds), .waddr(SW'(segment_index)),
        .wdata(lower_bound), .raddr(b_raddr), .rdata(st_rdata));
    ppse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_ends (
        .clk(clk), .we(wr_bounds), .waddr(SW'(segment_index)),
        .wdata(upper_bound), .raddr(b_raddr), .rdata(en_rdata));
    // second copy of starts, read at the found segment
    ppse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_starts_b (
        .clk(clk), .we(wr_bounds), .waddr(SW'(segment_index)),
        .wdata(lower_bound), .raddr(lo_reg), .rdata(st0_rdata));

    // coefficient memory
    logic [TW-1:0] c_raddr, c_waddr;
    logic [31:0]   c_rdata;
    logic [4:0]    cidx;
    always_comb
    begin
        cidx = j_reg + {3'b0, order_reg};
        c_raddr = TW'(32'(lo_reg) * MAX_COEFFICIENTS + 32'(cidx));
        c_waddr = TW'(32'(segment_index) * MAX_COEFFICIENTS + 32'(coefficient_index));
    end
    ppse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS * MAX_COEFFICIENTS)) u_coef (
        .clk(clk), .we(wr_coef), .waddr(c_waddr), .wdata(coefficient_value),
        .raddr(c_raddr), .rdata(c_rdata));

    // wrap fold
    logic signed [31:0] xw;
    always_comb
    begin
        xw = sample_point;
        if (wrap_unit)
        begin
            if (sample_point < 0)
            begin
                xw = $signed(Q_ONE - {16'b0, 16'((-sample_point) & 32'hFFFF)});
            end
            else if (sample_point > $signed(Q_ONE))
            begin
                xw = {16'b0, sample_point[15:0]};
            end
        end
    end

    // derivative coefficient
    logic [4:0]         m;
    logic signed [31:0] e_sat;
    logic               e_flag;
    logic signed [63:0] ek;
    logic [9:0]         kmul;
    always_comb
    begin
        m = ncoef - {3'b0, order_reg};
        kmul = 10'd1;
        if (order_reg == ORDER_VELOCITY)
        begin
            kmul = 10'(j_reg) + 10'd1;
        end
        else if (order_reg == ORDER_ACCEL)
        begin
            kmul = (10'(j_reg) + 10'd1) * (10'(j_reg) + 10'd2);
        end
        ek = $signed(c_rdata) * $signed({54'b0, kmul});
        e_flag = 1'b0;
        e_sat = ek[31:0];
        if (ek > QMAX)
        begin
            e_sat = 32'sh7FFF_FFFF;
            e_flag = 1'b1;
        end
        else if (ek < QMIN)
        begin
            e_sat = 32'sh8000_0000;
            e_flag = 1'b1;
        end
    end

    logic signed [63:0] dd;
    logic signed [63:0] hsum;
    logic signed [31:0] hsat;
    logic               hflag;
    always_comb
    begin
        dd = 64'(x_reg) - 64'($signed(st0_rdata));
        hsum = (prod_reg >>> 16) + 64'(e_sat);
        hflag = 1'b0;
        hsat = hsum[31:0];
        if (hsum > QMAX)
        begin
            hsat = 32'sh7FFF_FFFF;
            hflag = 1'b1;
        end
        else if (hsum < QMIN)
        begin
            hsat = 32'sh8000_0000;
            hflag = 1'b1;
        end
    end

    assign status.srch_done   = (lo_reg == hi_reg);
    assign status.order_bad   = (order_reg == ORDER_NONE) || (ncoef <= {3'b0, order_reg});
    // index runs below zero once the constant term has been added
    assign status.horner_last = (j_reg == 5'h1F);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_ph_reg <= 2'd0;
        end
        else if (cmd.op_start)
        begin
            clamp_ph_reg <= (kind == KIND_EVAL) ? 2'd1 : 2'd0;
        end
        else if (clamp_ph_reg != 2'd0)
        begin
            clamp_ph_reg <= clamp_ph_reg + 2'd1;
        end
    end

    logic signed [31:0] dsat;
    logic               dflag;
    always_comb
    begin
        dflag = 1'b0;
        dsat = dd[31:0];
        if (dd > QMAX)
        begin
            dsat = 32'sh7FFF_FFFF;
            dflag = 1'b1;
        end
        else if (dd < QMIN)
        begin
            dsat = 32'sh8000_0000;
            dflag = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(acc_reg) * 64'(d_reg);
        if (cmd.op_start)
        begin
            x_reg <= xw;
            order_reg <= derivative_order;
            sat_reg <= 1'b0;
        end
        if (clamp_ph_reg == 2'd1)
        begin
            if (x_reg <= $signed(st_rdata))
            begin
                x_reg <= $signed(st_rdata);
            end
        end
        if (clamp_ph_reg == 2'd2)
        begin
            if (x_reg >= $signed(en_rdata))
            begin
                x_reg <= $signed(en_rdata);
            end
        end
        if (cmd.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= SW'(nseg - 1'b1);
        end
        if (cmd.srch_step)
        begin
            if (x_reg < $signed(st_rdata))
            begin
                hi_reg <= (mid > lo_reg) ? mid - 1'b1 : lo_reg;
            end
            else if (x_reg > $signed(en_rdata))
            begin
                lo_reg <= mid + 1'b1;
            end
            else
            begin
                lo_reg <= mid;
                hi_reg <= mid;
            end
        end
        if (cmd.coef_load)
        begin
            j_reg <= m - 5'd1;
        end
        if (cmd.horner_init)
        begin
            acc_reg <= e_sat;
            d_reg <= dsat;
            sat_reg <= sat_reg | e_flag | dflag;
            j_reg <= j_reg - 5'd1;
        end
        if (cmd.horner_step)
        begin
            acc_reg <= hsat;
            sat_reg <= sat_reg | e_flag | hflag;
            j_reg <= j_reg - 5'd1;
        end
        if (cmd.result_zero)
        begin
            result_reg <= '0;
            sat_out_reg <= 1'b0;
        end
        if (cmd.result_take)
        begin
            result_reg <= acc_reg;
            sat_out_reg <= sat_reg;
        end
    end
    assign value = result_reg;
    assign saturated = sat_out_reg;
endmodule

### src/piecewise_polynomial_spline_eval.sv
// Piecewise polynomial spline evaluator, Q16.16.
// Input channel in: kind selects a bounds write, a coefficient write or an
// evaluate. Output channel out: one transfer per input transfer, value and
// saturated (zero for writes).
// Configuration: cfg_we, cfg_index (0 segments in use, 1 coefficients in
// use), cfg_data; written while idle.
// One item at a time: a write returns its result, registered, in the cycle
// after the input transfer. An evaluate does fold, clamp and search set-up,
// binary search steps (up to ceil(log2) of segments in use), coefficient
// fetch, C-1 Horner steps and a finish, C being the coefficients in use less
// the derivative order. An unused or too high order returns zero once the
// search is done.
// Input is not ready while a result waits; a stalled receiver holds the
// result steady. The next input transfer can follow in the cycle after the
// result transfer. Reset sets segments in use to 1, coefficients to 4; the
// tables hold nothing until written.
module piecewise_polynomial_spline_eval
    import ppse_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int MAX_COEFFICIENTS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    ppse_in_if.sink    in,
    ppse_out_if.source out,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data
);
    cmd_t    cmd;
    status_t status;
    logic    in_fire;
    assign in_fire = in.valid && in.ready;

    ppse_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .is_eval(in.kind == KIND_EVAL), .out_ready(out.ready), .status(status),
        .cmd(cmd), .in_ready(in.ready), .out_valid(out.valid));

    ppse_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .MAX_COEFFICIENTS(MAX_COEFFICIENTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_fire(in_fire), .kind(in.kind),
        .segment_index(in.segment_index), .coefficient_index(in.coefficient_index),
        .lower_bound(in.lower_bound), .upper_bound(in.upper_bound),
        .coefficient_value(in.coefficient_value), .sample_point(in.sample_point),
        .derivative_order(in.derivative_order), .wrap_unit(in.wrap_unit),
        .cmd(cmd), .status(status), .value(out.value), .saturated(out.saturated));
endmodule

### src/ppse_checker.sv
`include "assert_macros.svh"
module ppse_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [31:0] value,
    input logic saturated
);
    `ASSERT_IMPL(a_no_accept_busy, out_valid, !in_ready, "input taken while result waits")
    `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(saturated), "result dropped")
    `ASSERT_NEXT(a_one_result, in_valid && in_ready, !in_ready, "second item taken")
endmodule

bind piecewise_polynomial_spline_eval ppse_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .value(out.value),
    .saturated(out.saturated));
